// ----- hw/rtl/dps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and helpers for the dynamic priority scheduler.
package dps_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic signed [7:0] PRI_MIN = -8'sd128;

    typedef struct packed {
        logic              op;
        logic [2:0]        slot;
        logic [7:0]        proc_id;
        logic signed [7:0] start_priority;
        logic [7:0]        start_runtime;
    } in_t;

    typedef struct packed {
        logic              idle;
        logic [2:0]        chosen_slot;
        logic [7:0]        chosen_id;
        logic signed [7:0] priority_after;
        logic [7:0]        runtime_left;
        logic              finished;
    } out_t;

    // best entry seen so far as it travels down the row of cells
    typedef struct packed {
        logic              found;
        logic signed [7:0] pri;
        logic [7:0]        id;
        logic [7:0]        rt;
    } cand_t;

    function automatic logic signed [7:0] pri_dec(input logic signed [7:0] p);
        pri_dec = (p == PRI_MIN) ? PRI_MIN : p - 8'sd1;
    endfunction

endpackage

// ----- hw/rtl/dps_cell.sv -----
`timescale 1ns / 1ps
// One table entry of the scheduler plus its stage of the max-priority scan.
module dps_cell
    import dps_pkg::*;
#(
    parameter int IDX_W = 3,
    parameter int INDEX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  in_t              item,
    input  logic             upd,
    input  cand_t            cand_in,
    input  logic [IDX_W-1:0] slot_in,
    input  logic             tok_in,
    output cand_t            cand_out,
    output logic [IDX_W-1:0] slot_out,
    output logic             tok_out
);

    logic [7:0]        id_reg;
    logic signed [7:0] pri_reg;
    logic [7:0]        rt_reg;
    logic              ready_reg;

    cand_t             cand_reg, cand_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic              tok_reg;
    logic              take;
    logic [7:0]        rt_dec;

    // strict greater-than keeps the lower slot on a tie
    assign take = ready_reg && (!cand_in.found || (pri_reg > cand_in.pri));
    assign rt_dec = rt_reg - 8'd1;

    always_comb
    begin
        cand_next = cand_in;
        slot_next = slot_in;
        if (take)
        begin
            cand_next.found = 1'b1;
            cand_next.pri   = pri_reg;
            cand_next.id    = id_reg;
            cand_next.rt    = rt_reg;
            slot_next       = IDX_W'(INDEX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
            if (wr)
                ready_reg <= (item.start_runtime != 8'd0);
            else if (upd)
                ready_reg <= (rt_dec != 8'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        slot_reg <= slot_next;
        if (wr)
        begin
            id_reg  <= item.proc_id;
            pri_reg <= item.start_priority;
            rt_reg  <= item.start_runtime;
        end
        else if (upd)
        begin
            pri_reg <= pri_dec(pri_reg);
            rt_reg  <= rt_dec;
        end
    end

    assign cand_out = cand_reg;
    assign slot_out = slot_reg;
    assign tok_out  = tok_reg;

endmodule

// ----- hw/rtl/dynamic_priority_scheduler.sv -----
`timescale 1ns / 1ps
// Top level: process table as a row of cells with a rippling max-priority scan.
//
//  channel | ports                | handshake
//  --------+----------------------+-----------------------------------
//  item in | start, busy, item    | taken at edge with start && !busy
//  result  | strobe, result       | single-cycle strobe per result, no backpressure
//
// A load is written into its cell at the accept edge; busy stays low.
// A tick sends a token down the row, one cell per cycle. When the token
// leaves the last cell, the winner's cell (if any) is updated, busy drops
// and the result is strobed at that same edge. Busy stays high until then,
// and the next item can be taken once busy is low.
// Reset clears all ready bits and the control flops.
module dynamic_priority_scheduler
    import dps_pkg::*;
#(
    parameter int NUM_ENTRIES = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  item,
    output logic strobe,
    output out_t result
);

    localparam int IDX_W = $clog2(NUM_ENTRIES);

    cand_t            chain      [0:NUM_ENTRIES];
    logic [IDX_W-1:0] chain_slot [0:NUM_ENTRIES];
    logic             tok        [0:NUM_ENTRIES];

    logic busy_reg, busy_next;
    logic strobe_reg;
    out_t result_reg, result_next;
    logic load_acc, tick_acc, upd_en;
    cand_t last;
    logic [7:0] rt_new;

    assign load_acc = start && !busy_reg && (item.op == OP_LOAD);
    assign tick_acc = start && !busy_reg && (item.op == OP_TICK);

    assign chain[0]      = '0;
    assign chain_slot[0] = '0;
    assign tok[0]        = tick_acc;

    assign last   = chain[NUM_ENTRIES];
    assign upd_en = tok[NUM_ENTRIES] && last.found;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_ENTRIES; gi++)
        begin : g_cell
            dps_cell #(
                .IDX_W (IDX_W),
                .INDEX (gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .wr       (load_acc && (int'(item.slot) == gi)),
                .item     (item),
                .upd      (upd_en && (chain_slot[NUM_ENTRIES] == IDX_W'(gi))),
                .cand_in  (chain[gi]),
                .slot_in  (chain_slot[gi]),
                .tok_in   (tok[gi]),
                .cand_out (chain[gi+1]),
                .slot_out (chain_slot[gi+1]),
                .tok_out  (tok[gi+1])
            );
        end
    endgenerate

    assign rt_new = last.rt - 8'd1;

    always_comb
    begin
        result_next = '0;
        if (!last.found)
            result_next.idle = 1'b1;
        else
        begin
            result_next.chosen_slot    = 3'(chain_slot[NUM_ENTRIES]);
            result_next.chosen_id      = last.id;
            result_next.priority_after = pri_dec(last.pri);
            result_next.runtime_left   = rt_new;
            result_next.finished       = (rt_new == 8'd0);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (tick_acc)
            busy_next = 1'b1;
        else if (tok[NUM_ENTRIES])
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            strobe_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            strobe_reg <= tok[NUM_ENTRIES];
            if (tok[NUM_ENTRIES])
                result_reg <= result_next;
        end
    end

    assign busy   = busy_reg;
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

// ----- hw/rtl/dps_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the scheduler, bound to the top level.
module dps_checker
    import dps_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input in_t  item,
    input logic strobe,
    input out_t result
);

    // a tick cannot be accepted while busy, so results never come back to back
    a_no_double_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("result strobe in two consecutive cycles");

    a_free_at_result: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !busy)
        else $error("busy still high while a result is shown");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.op == OP_TICK)) |=> busy)
        else $error("accepted tick did not raise busy");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.idle) |-> ((result.chosen_slot == 3'd0) &&
            (result.chosen_id == 8'd0) && (result.priority_after == 8'sd0) &&
            (result.runtime_left == 8'd0) && !result.finished))
        else $error("idle result carries nonzero fields");

    a_finish_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.idle) |-> (result.finished == (result.runtime_left == 8'd0)))
        else $error("finished flag disagrees with runtime left");

endmodule

bind dynamic_priority_scheduler dps_checker u_dps_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
);
